### sv/ffas_pkg.sv
// ----------------------------------------------------------------------------
// ffas_pkg
// Shared types and constants of the first-fit aligned sub-allocator.
// ----------------------------------------------------------------------------
package ffas_pkg;

  // default depth of the free chunk table
  localparam int unsigned MAX_CHUNKS_DEFAULT = 16;

  // managed block size after reset
  localparam logic [31:0] RESET_BLOCK_SIZE = 32'd268435456;

  // operation codes of a request
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_FIT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  // one free chunk: start offset and length in bytes
  typedef struct packed {
    logic [31:0] start;
    logic [32:0] length;
  } chunk_t;

endpackage

### sv/ffas_req_if.sv
// ----------------------------------------------------------------------------
// ffas_req_if
// Request channel: valid/ready handshake with op, size and alignment.
// ----------------------------------------------------------------------------
interface ffas_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] request_size;
  logic [4:0]  align_log2;

  modport source (output valid, output op, output request_size, output align_log2,
                  input ready);
  modport sink   (input valid, input op, input request_size, input align_log2,
                  output ready);
endinterface

### sv/ffas_rsp_if.sv
// ----------------------------------------------------------------------------
// ffas_rsp_if
// Response channel: valid/ready handshake with status and region offset.
// ----------------------------------------------------------------------------
interface ffas_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] region_offset;

  modport source (output valid, output status, output region_offset, input ready);
  modport sink   (input valid, input status, input region_offset, output ready);
endinterface

### sv/first_fit_aligned_suballocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_aligned_suballocator_top
// First-fit aligned sub-allocator over one memory block, free chunks held
// in a small table walked by a sequencer.
// ----------------------------------------------------------------------------
// One request transaction is handled at a time; ready is high only while the
// sequencer is idle. A restart goes straight to the respond state. An
// allocate reads the free chunk table (one write and one registered read
// port) one entry at a time: each chunk examined takes three steps (align,
// sum, compare), with the read of the next entry overlapping the compare. A
// split that keeps padding and tail moves every later entry up by one, a
// consumed chunk moves every later entry down by one, with a read and a write
// state per moved entry, and the result then goes to the respond state. After
// reset the init state sets up the table before the first request is taken.
// The response sits in an output register: a result that is not taken holds
// the next result in the sequencer, which then holds off the input.
// ----------------------------------------------------------------------------
module first_fit_aligned_suballocator_top
  import ffas_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  ffas_req_if.sink     req,
  ffas_rsp_if.source   rsp
);

  localparam int unsigned IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned NW = $clog2(MAX_CHUNKS + 1);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_CHUNKS);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EVAL,
    S_SUM,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_WR_TAIL,
    S_RESPOND
  } state_t;

  state_t        state;
  logic [31:0]   pool_bytes;
  logic [NW-1:0] n_used;
  logic [IW-1:0] idx;
  logic [IW-1:0] mv_idx;
  logic [31:0]   size_r;
  logic [31:0]   mask_r;
  logic [31:0]   s_r;
  logic [32:0]   len_r;
  logic [31:0]   pad_r;
  logic [32:0]   aligned_r;
  logic [33:0]   need_r;
  logic [31:0]   tail_start_r;
  logic [32:0]   tail_r;
  status_t       res_status;
  logic [31:0]   res_offset;
  logic          out_valid;
  status_t       out_status;
  logic [31:0]   out_offset;

  // chunk table
  chunk_t        mem [MAX_CHUNKS];
  chunk_t        rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  chunk_t        wr_data;

  // alignment step of the current chunk
  logic [31:0]   eval_pad;
  logic [32:0]   eval_aligned;
  // fit check of the current chunk
  logic [34:0]   diff;
  logic          fit;
  logic [32:0]   tail;
  logic          has_pad;
  logic          has_tail;
  logic          is_last;
  logic          table_full;
  logic          up_needed;
  logic          dn_needed;
  logic [IW-1:0] idx_p1;
  logic          accept;

  assign accept = req.valid && req.ready;

  assign eval_pad     = (~rd_data.start + 32'd1) & mask_r;
  assign eval_aligned = ({1'b0, rd_data.start} + {1'b0, mask_r}) & ~{1'b0, mask_r};

  assign diff       = {2'b00, len_r} - {1'b0, need_r};
  assign fit        = !diff[34];
  assign tail       = diff[32:0];
  assign has_pad    = (pad_r != 32'd0);
  assign has_tail   = (tail != 33'd0);
  assign is_last    = ((NW'(idx) + NW'(1)) == n_used);
  assign table_full = (n_used == MAX_N);
  assign up_needed  = ((n_used - NW'(1)) > NW'(idx));
  assign dn_needed  = (NW'(idx) < (n_used - NW'(1)));
  assign idx_p1     = idx + IW'(1);

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.region_offset = out_offset;

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // table port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    unique case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = '{start: 32'd0, length: {1'b0, RESET_BLOCK_SIZE}};
      end
      S_IDLE: begin
        if (accept && req.op == OP_RESTART) begin
          wr_en   = 1'b1;
          wr_data = '{start: 32'd0, length: {1'b0, pool_bytes}};
        end
      end
      S_DECIDE: begin
        if (!fit) begin
          rd_addr = idx_p1;
        end else if (has_pad && has_tail) begin
          if (!table_full) begin
            wr_en   = 1'b1;
            wr_addr = idx;
            wr_data = '{start: s_r, length: {1'b0, pad_r}};
          end
        end else if (has_pad) begin
          wr_en   = 1'b1;
          wr_addr = idx;
          wr_data = '{start: s_r, length: {1'b0, pad_r}};
        end else if (has_tail) begin
          wr_en   = 1'b1;
          wr_addr = idx;
          wr_data = '{start: tail_start_r, length: tail};
        end
      end
      S_UP_RD: rd_addr = mv_idx;
      S_UP_WR: begin
        wr_en   = 1'b1;
        wr_addr = mv_idx + IW'(1);
        wr_data = rd_data;
      end
      S_DN_RD: rd_addr = mv_idx + IW'(1);
      S_DN_WR: begin
        wr_en   = 1'b1;
        wr_addr = mv_idx;
        wr_data = rd_data;
      end
      S_WR_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = idx_p1;
        wr_data = '{start: tail_start_r, length: tail_r};
      end
      default: ;
    endcase
  end

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      pool_bytes <= RESET_BLOCK_SIZE;
      n_used     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pool_bytes <= cfg_wr_data;
      end
      if (out_valid && rsp.ready && state != S_RESPOND) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          n_used <= NW'(1);
          state  <= S_IDLE;
        end

        S_IDLE: begin
          if (accept) begin
            size_r     <= req.request_size;
            mask_r     <= ~(32'hFFFF_FFFF << req.align_log2);
            idx        <= '0;
            res_offset <= 32'd0;
            if (req.op == OP_RESTART) begin
              n_used     <= (pool_bytes != 32'd0) ? NW'(1) : '0;
              res_status <= STATUS_OK;
              state      <= S_RESPOND;
            end else if (n_used == '0) begin
              res_status <= STATUS_NO_FIT;
              state      <= S_RESPOND;
            end else begin
              state <= S_EVAL;
            end
          end
        end

        // round the chunk start up to the alignment
        S_EVAL: begin
          s_r       <= rd_data.start;
          len_r     <= rd_data.length;
          pad_r     <= eval_pad;
          aligned_r <= eval_aligned;
          state     <= S_SUM;
        end

        // bytes needed and start of the tail
        S_SUM: begin
          need_r       <= {2'b00, pad_r} + {2'b00, size_r};
          tail_start_r <= aligned_r[31:0] + size_r;
          state        <= S_DECIDE;
        end

        // fit check and split decision
        S_DECIDE: begin
          if (!fit) begin
            if (is_last) begin
              res_status <= STATUS_NO_FIT;
              res_offset <= 32'd0;
              state      <= S_RESPOND;
            end else begin
              idx   <= idx_p1;
              state <= S_EVAL;
            end
          end else if (has_pad && has_tail) begin
            if (table_full) begin
              res_status <= STATUS_FULL;
              res_offset <= 32'd0;
              state      <= S_RESPOND;
            end else begin
              res_status <= STATUS_OK;
              res_offset <= aligned_r[31:0];
              tail_r     <= tail;
              if (up_needed) begin
                mv_idx <= IW'(n_used - NW'(1));
                state  <= S_UP_RD;
              end else begin
                state <= S_WR_TAIL;
              end
            end
          end else if (has_pad || has_tail) begin
            res_status <= STATUS_OK;
            res_offset <= aligned_r[31:0];
            state      <= S_RESPOND;
          end else begin
            res_status <= STATUS_OK;
            res_offset <= aligned_r[31:0];
            n_used     <= n_used - NW'(1);
            if (dn_needed) begin
              mv_idx <= idx;
              state  <= S_DN_RD;
            end else begin
              state <= S_RESPOND;
            end
          end
        end

        // open a slot after the split chunk
        S_UP_RD: state <= S_UP_WR;
        S_UP_WR: begin
          if (mv_idx > idx_p1) begin
            mv_idx <= mv_idx - IW'(1);
            state  <= S_UP_RD;
          end else begin
            state <= S_WR_TAIL;
          end
        end

        S_WR_TAIL: begin
          n_used <= n_used + NW'(1);
          state  <= S_RESPOND;
        end

        // close the gap of a consumed chunk
        S_DN_RD: state <= S_DN_WR;
        S_DN_WR: begin
          if ((NW'(mv_idx) + NW'(1)) < n_used) begin
            mv_idx <= mv_idx + IW'(1);
            state  <= S_DN_RD;
          end else begin
            state <= S_RESPOND;
          end
        end

        // hand the result to the output register once it is free
        S_RESPOND: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_offset <= res_offset;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
